// ===== hw/rtl/fbcjk_pkg.sv =====
package fbcjk_pkg;

   // byte codes of the unit format
   localparam logic [7:0] UNIT_BIAS = 8'h4E;
   localparam logic [7:0] TAIL_MARK = 8'h3D;
   localparam logic [7:0] MAX_TAIL  = 8'd6;

   // framing sizes
   localparam int         STORE_DEPTH  = 11;
   localparam logic [3:0] GROUP_BYTES  = 4'd7;   // raw bytes in one group
   localparam logic [3:0] GROUP_UNITS  = 4'd8;   // unit bytes in one group
   localparam logic [3:0] HOLD_LIMIT   = 4'd11;  // held bytes that prove a full group
   localparam logic [3:0] MARK_BYTES   = 4'd2;   // '=' and the tail length

   typedef struct packed {
      logic [7:0] byte_in;
      logic       last_in;
   } req_type;

   typedef struct packed {
      logic [7:0] byte_out;
      logic       last_out;
   } rsp_type;

   // one unit of work handed from the front to the back
   typedef struct packed {
      logic        dec;    // 1: plain bytes, 0: unit pairs
      logic [55:0] data;   // group value, most significant first
      logic [3:0]  cnt;    // data bytes to send
      logic        mark;   // append '=' and k
      logic [2:0]  k;
      logic        last;   // final word carries last_out
   } job_type;

   typedef struct packed {
      logic [3:0] held;
      logic       mode;
   } front_stat_type;

   // unit bytes sent for a partial group of k raw bytes
   function automatic logic [3:0] tail_bytes(input logic [2:0] k);
      logic [3:0] n;
      case (k)
         3'd1: n = 4'd2;
         3'd2: n = 4'd4;
         3'd3: n = 4'd4;
         3'd4: n = 4'd6;
         3'd5: n = 4'd6;
         3'd6: n = 4'd8;
         default: n = 4'd0;
      endcase
      return n;
   endfunction

endpackage

// ===== hw/rtl/fbcjk_front.sv =====
module fbcjk_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic                          csr_wdata,
   input  logic                          accept,
   input  fbcjk_pkg::req_type            req_data,
   output logic                          job_push,
   output fbcjk_pkg::job_type            job,
   output fbcjk_pkg::front_stat_type     stat
);

   logic [3:0] count_ff, count_in;
   logic       mode_ff, mode_in;
   logic [7:0] prev_ff, prev_in;
   logic [7:0] store_ff [fbcjk_pkg::STORE_DEPTH];
   logic [7:0] store_in [fbcjk_pkg::STORE_DEPTH];

   logic [7:0]  view [fbcjk_pkg::STORE_DEPTH];
   logic [3:0]  c;
   logic        last;
   logic [7:0]  b;
   logic        marker;
   logic [3:0]  nb;
   logic [55:0] enc_v;
   logic [55:0] dec_v;

   assign b    = req_data.byte_in;
   assign last = req_data.last_in;
   assign c    = count_ff + 4'd1;

   // held bytes with the incoming word dropped in at its slot
   always_comb begin
      for (int i = 0; i < fbcjk_pkg::STORE_DEPTH; i++) begin
         view[i] = (count_ff == 4'(i)) ? b : store_ff[i];
      end
   end

   // closing marker: '=' followed by a tail length of 1..6
   assign marker = (c >= fbcjk_pkg::MARK_BYTES) && (prev_ff == fbcjk_pkg::TAIL_MARK) &&
                   (b != 8'd0) && (b <= fbcjk_pkg::MAX_TAIL);
   assign nb = (last && marker) ? (c - fbcjk_pkg::MARK_BYTES) : fbcjk_pkg::GROUP_UNITS;

   always_comb begin
      enc_v = '0;
      for (int i = 0; i < 7; i++) begin
         if (4'(i) < c) begin
            enc_v[55 - 8 * i -: 8] = view[i];
         end
      end
   end

   always_comb begin
      logic [7:0] hi;
      logic [7:0] lo;
      dec_v = '0;
      for (int j = 0; j < 4; j++) begin
         hi = '0;
         lo = '0;
         if (4'(2 * j) < nb) begin
            hi = view[2 * j] - fbcjk_pkg::UNIT_BIAS;
         end
         if (4'(2 * j + 1) < nb) begin
            lo = view[2 * j + 1];
         end
         dec_v[55 - 14 * j -: 14] = {hi[5:0], lo};
      end
   end

   always_comb begin
      count_in = count_ff;
      mode_in  = mode_ff;
      prev_in  = prev_ff;
      store_in = store_ff;
      job_push = 1'b0;
      job      = '0;
      if (csr_we) begin
         mode_in  = csr_wdata;
         count_in = '0;
      end else if (accept) begin
         prev_in = b;
         if (count_ff < 4'(fbcjk_pkg::STORE_DEPTH)) begin
            store_in[count_ff] = b;
         end
         if (!mode_ff) begin
            count_in = c;
            if (c >= fbcjk_pkg::GROUP_BYTES) begin
               job_push  = 1'b1;
               job.data  = enc_v;
               job.cnt   = fbcjk_pkg::GROUP_UNITS;
               job.last  = last;
               count_in  = '0;
            end else if (last) begin
               job_push  = 1'b1;
               job.data  = enc_v;
               job.cnt   = fbcjk_pkg::tail_bytes(c[2:0]);
               job.mark  = 1'b1;
               job.k     = c[2:0];
               job.last  = 1'b1;
               count_in  = '0;
            end
         end else if (!last) begin
            count_in = c;
            if (c >= fbcjk_pkg::HOLD_LIMIT) begin
               job_push = 1'b1;
               job.dec  = 1'b1;
               job.data = dec_v;
               job.cnt  = fbcjk_pkg::GROUP_BYTES;
               // keep the bytes past the decoded group
               for (int i = 0; i < fbcjk_pkg::STORE_DEPTH - 8; i++) begin
                  store_in[i] = view[i + 8];
               end
               count_in = c - fbcjk_pkg::GROUP_UNITS;
            end
         end else begin
            count_in = '0;
            if (marker) begin
               job_push = 1'b1;
               job.dec  = 1'b1;
               job.data = dec_v;
               job.cnt  = {1'b0, b[2:0]};
               job.last = 1'b1;
            end else if (c >= fbcjk_pkg::GROUP_UNITS) begin
               // stray bytes after one full group are dropped
               job_push = 1'b1;
               job.dec  = 1'b1;
               job.data = dec_v;
               job.cnt  = fbcjk_pkg::GROUP_BYTES;
               job.last = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         mode_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         mode_ff  <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_ff  <= prev_in;
      store_ff <= store_in;
   end

   assign stat.held = count_ff;
   assign stat.mode = mode_ff;

endmodule

// ===== hw/rtl/fbcjk_queue.sv =====
module fbcjk_queue #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  fbcjk_pkg::job_type push_job,
   output logic               full,
   input  logic               take,
   output logic               valid,
   output fbcjk_pkg::job_type head_job
);

   localparam int PW = $clog2(DEPTH);
   localparam int LW = $clog2(DEPTH + 1);

   fbcjk_pkg::job_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ff, wr_in;
   logic [PW-1:0] rd_ff, rd_in;
   logic [LW-1:0] level_ff, level_in;

   assign full     = (level_ff == LW'(DEPTH));
   assign valid    = (level_ff != '0);
   assign head_job = mem_ff[rd_ff];

   // pointers wrap at the last entry so any depth works
   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      end
      if (take) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      end
      level_in = level_ff + LW'(push) - LW'(take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         level_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_job;
      end
   end

endmodule

// ===== hw/rtl/fbcjk_back.sv =====
module fbcjk_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  fbcjk_pkg::job_type q_job,
   output logic               q_take,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output fbcjk_pkg::rsp_type rsp_data
);

   logic        busy_ff, busy_in;
   logic [55:0] data_ff, data_in;
   logic [3:0]  pos_ff, pos_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [3:0]  total_ff, total_in;
   logic        dec_ff, dec_in;
   logic [2:0]  k_ff, k_in;
   logic        last_ff, last_in;

   logic       final_word;
   logic       done;
   logic [7:0] unit_hi;
   logic [7:0] data_byte;

   assign final_word = (pos_ff == total_ff - 4'd1);
   assign done       = !busy_ff || (rsp_pop && final_word);
   assign q_take     = done && q_valid;
   assign rsp_empty  = !busy_ff;

   assign unit_hi = fbcjk_pkg::UNIT_BIAS + {2'b00, data_ff[55:50]};

   always_comb begin
      if (dec_ff) begin
         data_byte = data_ff[55:48];
      end else if (pos_ff[0]) begin
         data_byte = data_ff[49:42];
      end else begin
         data_byte = unit_hi;
      end
      if (pos_ff < cnt_ff) begin
         rsp_data.byte_out = data_byte;
      end else if (pos_ff == cnt_ff) begin
         rsp_data.byte_out = fbcjk_pkg::TAIL_MARK;
      end else begin
         rsp_data.byte_out = {5'b00000, k_ff};
      end
      rsp_data.last_out = last_ff && final_word;
   end

   always_comb begin
      busy_in  = busy_ff;
      data_in  = data_ff;
      pos_in   = pos_ff;
      cnt_in   = cnt_ff;
      total_in = total_ff;
      dec_in   = dec_ff;
      k_in     = k_ff;
      last_in  = last_ff;
      if (q_take) begin
         busy_in  = 1'b1;
         data_in  = q_job.data;
         pos_in   = '0;
         cnt_in   = q_job.cnt;
         total_in = q_job.cnt + (q_job.mark ? fbcjk_pkg::MARK_BYTES : 4'd0);
         dec_in   = q_job.dec;
         k_in     = q_job.k;
         last_in  = q_job.last;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (rsp_pop) begin
         pos_in = pos_ff + 4'd1;
         if (dec_ff) begin
            data_in = data_ff << 8;
         end else if (pos_ff[0]) begin
            data_in = data_ff << 14;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff  <= data_in;
      pos_ff   <= pos_in;
      cnt_ff   <= cnt_in;
      total_ff <= total_in;
      dec_ff   <= dec_in;
      k_ff     <= k_in;
      last_ff  <= last_in;
   end

endmodule

// ===== hw/rtl/fourteen_bit_cjk_stream_codec_core.sv =====
// channel   ports                              direction  moves
// input     req_push, req_full, req_data       in         one stream word + end flag
// result    rsp_empty, rsp_pop, rsp_data       out        one coded word + end flag
// control   csr_we, csr_wdata                  in         decode_mode, no read-back
//
// an input word is taken every cycle while the job queue has room; the front
// hands each group, whole or closing, to the back as a job, and the back sends
// one word per cycle while rsp_pop is high, from a 56-bit group register, so
// the sustained input rate is set by the single result port
// reset (synchronous) clears the held count, the mode, the queue and the back
// a stalled result port fills the job queue, after which req_full rises
module fourteen_bit_cjk_stream_codec_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  fbcjk_pkg::req_type req_data,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output fbcjk_pkg::rsp_type rsp_data,
   input  logic               csr_we,
   input  logic               csr_wdata
);

   // handshake on the input side
   logic accept;

   // jobs between the front and the back
   logic                      job_push;
   fbcjk_pkg::job_type        job;
   logic                      q_full;
   logic                      q_valid;
   logic                      q_take;
   fbcjk_pkg::job_type        q_job;
   fbcjk_pkg::front_stat_type stat;

   // the front only stalls when the queue cannot take a job
   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   // front: holds raw words, spots full groups and closing markers
   fbcjk_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .req_data  (req_data),
      .job_push  (job_push),
      .job       (job),
      .stat      (stat)
   );

   // short job queue so either side can stall on its own
   fbcjk_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (job),
      .full     (q_full),
      .take     (q_take),
      .valid    (q_valid),
      .head_job (q_job)
   );

   // back: serializes each job into result words
   fbcjk_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_job     (q_job),
      .q_take    (q_take),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   // held count never reaches the group limit, it is resolved on arrival
   held_in_range: assert property (@(posedge clock) disable iff (reset)
      stat.held < fbcjk_pkg::HOLD_LIMIT)
      else $error("held word count out of range");

   // a mode write drops any half-built group
   mode_write_clears: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> (stat.held == 4'd0))
      else $error("held words survived a mode write");

   // an idle back picks up a waiting job on the next edge
   back_picks_up: assert property (@(posedge clock) disable iff (reset)
      (q_valid && rsp_empty) |=> !rsp_empty)
      else $error("back left a queued job waiting");

   // encoding only ever holds a partial group
   encode_short: assert property (@(posedge clock) disable iff (reset)
      !stat.mode |-> (stat.held < fbcjk_pkg::GROUP_BYTES))
      else $error("encode held a full group");

endmodule

// ===== dv/tb_fourteen_bit_cjk_stream_codec_core.sv =====
`timescale 1ns / 1ps

module tb_fourteen_bit_cjk_stream_codec_core;

   // cycles allowed for words still inside the block when nothing more is due
   localparam int SETTLE_CYCLES = 24;
   // known count in a table row that leaves the result to the predictor
   localparam int BY_PREDICTOR = -1;
   localparam int WORDS_PER_PHASE = 5;

   typedef enum logic {ROW_WORD, ROW_MODE} row_kind_type;

   // one line of the directed table; known holds up to 8 bytes, first byte on top
   typedef struct packed {
      row_kind_type kind;
      logic [7:0]   value;
      logic         last;
      int           known_cnt;
      logic [63:0]  known;
   } stim_row_type;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_push  = 1'b0;
   logic               req_full;
   fbcjk_pkg::req_type req_data  = '0;
   logic               rsp_empty;
   logic               rsp_pop   = 1'b0;
   fbcjk_pkg::rsp_type rsp_data;
   logic               csr_we    = 1'b0;
   logic               csr_wdata = 1'b0;

   // codec image: held stream bytes, their count and the current mode
   logic [7:0] held_bytes [16];
   int         held_cnt = 0;
   logic       dec_mode = 1'b0;

   logic [7:0]         out_bytes  [$];   // bytes produced by one accepted word
   logic [7:0]         feed_bytes [$];   // next stream to push in
   fbcjk_pkg::rsp_type words_due  [$];   // coded words still owed by the block
   fbcjk_pkg::rsp_type due_word;

   int error_cnt  = 0;
   int idle_pct   = 0;
   int stall_pct  = 0;
   int words_sent = 0;

   fourteen_bit_cjk_stream_codec_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // four 14-bit units of a 56-bit group, each as bias+high6 then low8
   function automatic logic [63:0] unit_pairs(input logic [55:0] v);
      logic [63:0] r;
      logic [13:0] u;
      for (int j = 0; j < 4; j++) begin
         u = v[55 - 14 * j -: 14];
         r[63 - 16 * j -: 16] = {fbcjk_pkg::UNIT_BIAS + {2'b00, u[13:8]}, u[7:0]};
      end
      return r;
   endfunction

   function automatic void emit_units(input logic [55:0] v, input int units);
      logic [63:0] r;
      r = unit_pairs(v);
      for (int i = 0; i < 2 * units; i++)
         out_bytes.push_back(r[63 - 8 * i -: 8]);
   endfunction

   function automatic void emit_plain(input logic [55:0] v, input int cnt);
      for (int i = 0; i < cnt; i++)
         out_bytes.push_back(v[55 - 8 * i -: 8]);
   endfunction

   // big-endian value of the first n held bytes, zero padded to 7
   function automatic logic [55:0] held_group(input int n);
      logic [55:0] v;
      v = '0;
      for (int i = 0; i < 7; i++)
         v = {v[47:0], (i < n) ? held_bytes[i] : 8'h00};
      return v;
   endfunction

   // 56 bits carried by the first nb held unit bytes, missing bytes as zero
   function automatic logic [55:0] held_units(input int nb);
      logic [55:0] v;
      logic [7:0]  hi;
      logic [7:0]  lo;
      v = '0;
      for (int j = 0; j < 4; j++) begin
         hi = (2 * j < nb) ? ((held_bytes[2 * j] - fbcjk_pkg::UNIT_BIAS) & 8'h3F) : 8'h00;
         lo = (2 * j + 1 < nb) ? held_bytes[2 * j + 1] : 8'h00;
         v  = {v[41:0], hi[5:0], lo};
      end
      return v;
   endfunction

   // advance the codec image by one accepted word, bytes land in out_bytes
   function automatic void predict_codec(input fbcjk_pkg::req_type w);
      int         c;
      logic [7:0] k;
      out_bytes.delete();
      if (held_cnt > 15)
         held_cnt = 0;
      held_bytes[held_cnt] = w.byte_in;
      held_cnt++;
      c = held_cnt;
      if (!dec_mode) begin
         if (c >= fbcjk_pkg::GROUP_BYTES) begin
            emit_units(held_group(7), 4);
         end else if (w.last_in) begin
            // partial group: ceil(8k/14) units, then '=' and k
            emit_units(held_group(c), (8 * c + 13) / 14);
            out_bytes.push_back(fbcjk_pkg::TAIL_MARK);
            out_bytes.push_back(8'(c));
         end
         if (c >= fbcjk_pkg::GROUP_BYTES || w.last_in)
            held_cnt = 0;
      end else if (!w.last_in) begin
         // eleven held bytes prove the first eight are a whole group
         if (c >= fbcjk_pkg::HOLD_LIMIT) begin
            emit_plain(held_units(8), 7);
            for (int i = 0; i < c - 8; i++)
               held_bytes[i] = held_bytes[i + 8];
            held_cnt = c - 8;
         end
      end else begin
         k = (c >= 2) ? held_bytes[c - 1] : 8'h00;
         if (c >= 2 && held_bytes[c - 2] == fbcjk_pkg::TAIL_MARK && k >= 1 &&
             k <= fbcjk_pkg::MAX_TAIL)
            emit_plain(held_units(c - 2), k);
         else if (c >= fbcjk_pkg::GROUP_UNITS)
            emit_plain(held_units(8), 7);
         // anything else left over is dropped at stream end
         held_cnt = 0;
      end
   endfunction

   // well-formed unit stream for a raw byte stream, into out_bytes
   function automatic void encode_stream(input int len);
      logic [55:0] v;
      int          n;
      out_bytes.delete();
      for (int g = 0; g < len; g += 7) begin
         n = (len - g < 7) ? len - g : 7;
         v = '0;
         for (int i = 0; i < 7; i++)
            v = {v[47:0], (i < n) ? feed_bytes[g + i] : 8'h00};
         if (n == 7) begin
            emit_units(v, 4);
         end else begin
            emit_units(v, (8 * n + 13) / 14);
            out_bytes.push_back(fbcjk_pkg::TAIL_MARK);
            out_bytes.push_back(8'(n));
         end
      end
   endfunction

   function automatic stim_row_type stim_row(input row_kind_type kind,
                                             input logic [7:0] value,
                                             input logic last, input int known_cnt,
                                             input logic [63:0] known);
      stim_row_type r;
      r.kind      = kind;
      r.value     = value;
      r.last      = last;
      r.known_cnt = known_cnt;
      r.known     = known;
      return r;
   endfunction

   // push one word, then book what it should produce
   task automatic send_word(input fbcjk_pkg::req_type w, input int known_cnt,
                            input logic [63:0] known);
      fbcjk_pkg::rsp_type e;
      while ($urandom_range(99) < idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      words_sent++;
      predict_codec(w);
      if (known_cnt != BY_PREDICTOR) begin
         out_bytes.delete();
         for (int i = 0; i < known_cnt; i++)
            out_bytes.push_back(known[63 - 8 * i -: 8]);
      end
      foreach (out_bytes[i]) begin
         e.byte_out = out_bytes[i];
         e.last_out = w.last_in && (i == out_bytes.size() - 1);
         words_due.push_back(e);
      end
   endtask

   // mode writes only once the block has drained
   task automatic set_mode(input logic m);
      req_push <= 1'b0;
      while (words_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= m;
      @(posedge clock);
      csr_we   <= 1'b0;
      dec_mode = m;
      held_cnt = 0;
   endtask

   // one stream: raw bytes when encoding, mostly clean unit streams when decoding
   task automatic send_stream(input logic decoding);
      int                 len;
      int                 pick;
      int                 pos;
      logic               closes;
      fbcjk_pkg::req_type w;
      len = $urandom_range(1, 18);
      pick = $urandom_range(9);
      feed_bytes.delete();
      for (int i = 0; i < len; i++)
         feed_bytes.push_back(8'($urandom_range(255)));
      if (!decoding) begin
         closes = ($urandom_range(7) != 0);
      end else begin
         closes = ($urandom_range(15) != 0);
         if (pick != 9) begin
            encode_stream(len);
            feed_bytes = out_bytes;
            if (pick == 7) begin
               // corrupt one byte
               pos = $urandom_range(feed_bytes.size() - 1);
               feed_bytes[pos] = 8'($urandom_range(255));
            end else if (pick == 8) begin
               // cut the stream short
               pos = $urandom_range(1, feed_bytes.size());
               while (feed_bytes.size() > pos)
                  void'(feed_bytes.pop_back());
            end
         end
         // pick 9 leaves raw noise in place of units
      end
      foreach (feed_bytes[i]) begin
         w.byte_in = feed_bytes[i];
         w.last_in = closes && (i == feed_bytes.size() - 1);
         send_word(w, BY_PREDICTOR, '0);
      end
   endtask

   // result side: check each popped word against the oldest one due
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (words_due.size() == 0) begin
            $display("%0t: unexpected word, expected none, got byte_out=%h last_out=%b",
                     $time, rsp_data.byte_out, rsp_data.last_out);
            error_cnt++;
         end else begin
            due_word = words_due.pop_front();
            if (rsp_data.byte_out !== due_word.byte_out) begin
               $display("%0t: byte_out expected %h got %h",
                        $time, due_word.byte_out, rsp_data.byte_out);
               error_cnt++;
            end
            if (rsp_data.last_out !== due_word.last_out) begin
               $display("%0t: last_out expected %b got %b",
                        $time, due_word.last_out, rsp_data.last_out);
               error_cnt++;
            end
         end
      end
      rsp_pop <= ($urandom_range(99) >= stall_pct);
   end

   initial begin
      stim_row_type       rows [$];
      fbcjk_pkg::req_type w;

      // encode after reset: single-byte tails at both extremes
      rows.push_back(stim_row(ROW_WORD, 8'h00, 1'b1, 4, 64'h4E00_3D01_0000_0000));
      rows.push_back(stim_row(ROW_WORD, 8'hFF, 1'b1, 4, 64'h8DC0_3D01_0000_0000));
      // full group of all ones: every unit at its top value
      for (int i = 0; i < 6; i++)
         rows.push_back(stim_row(ROW_WORD, 8'hFF, 1'b0, 0, '0));
      rows.push_back(stim_row(ROW_WORD, 8'hFF, 1'b0, 8, 64'h8DFF_8DFF_8DFF_8DFF));
      // six-byte tail, the longest partial group
      rows.push_back(stim_row(ROW_WORD, 8'h01, 1'b0, BY_PREDICTOR, '0));
      rows.push_back(stim_row(ROW_WORD, 8'h80, 1'b0, BY_PREDICTOR, '0));
      rows.push_back(stim_row(ROW_WORD, 8'h7F, 1'b0, BY_PREDICTOR, '0));
      rows.push_back(stim_row(ROW_WORD, 8'h00, 1'b0, BY_PREDICTOR, '0));
      rows.push_back(stim_row(ROW_WORD, 8'h55, 1'b0, BY_PREDICTOR, '0));
      rows.push_back(stim_row(ROW_WORD, 8'hAA, 1'b1, BY_PREDICTOR, '0));
      rows.push_back(stim_row(ROW_MODE, 8'h01, 1'b0, 0, '0));
      // decode a one-byte tail of zero
      rows.push_back(stim_row(ROW_WORD, fbcjk_pkg::UNIT_BIAS, 1'b0, 0, '0));
      rows.push_back(stim_row(ROW_WORD, 8'h00, 1'b0, 0, '0));
      rows.push_back(stim_row(ROW_WORD, fbcjk_pkg::TAIL_MARK, 1'b0, 0, '0));
      rows.push_back(stim_row(ROW_WORD, 8'h01, 1'b1, 1, 64'h0000_0000_0000_0000));
      // '=' with a length of seven is no marker, too short to be a group
      rows.push_back(stim_row(ROW_WORD, fbcjk_pkg::TAIL_MARK, 1'b0, 0, '0));
      rows.push_back(stim_row(ROW_WORD, 8'h07, 1'b1, 0, '0));
      // lone stray byte at stream end is dropped
      rows.push_back(stim_row(ROW_WORD, 8'hAB, 1'b1, 0, '0));
      // high byte below the bias wraps instead of borrowing
      rows.push_back(stim_row(ROW_WORD, 8'h00, 1'b0, 0, '0));
      rows.push_back(stim_row(ROW_WORD, 8'h00, 1'b0, 0, '0));
      rows.push_back(stim_row(ROW_WORD, fbcjk_pkg::TAIL_MARK, 1'b0, 0, '0));
      rows.push_back(stim_row(ROW_WORD, 8'h01, 1'b1, 1, 64'hC800_0000_0000_0000));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         if (rows[i].kind == ROW_MODE) begin
            set_mode(rows[i].value[0]);
         end else begin
            w.byte_in = rows[i].value;
            w.last_in = rows[i].last;
            send_word(w, rows[i].known_cnt, rows[i].known);
         end
      end

      // random streams: each idling pattern once per mode
      for (int p = 0; p < 8; p++) begin
         case (p / 2)
            0: begin
               idle_pct  = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct  = 77;
               stall_pct = 0;
            end
            2: begin
               idle_pct  = 0;
               stall_pct = 77;
            end
            default: begin
               idle_pct  = 18;
               stall_pct = 18;
            end
         endcase
         set_mode(p[0]);
         words_sent = 0;
         while (words_sent < WORDS_PER_PHASE)
            send_stream(p[0]);
      end

      // drain with the result side wide open so stray words show up
      req_push <= 1'b0;
      stall_pct = 0;
      while (words_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_cnt == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("%0t: timeout, %0d words still due", $time, words_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
